/* sv/script_lexer_tokenizer_macros.svh */
// Assertion helpers shared by the scanner modules.
// Every helper samples on clk_i and is disabled while rst_ni is low.
`ifndef SCRIPT_LEXER_TOKENIZER_MACROS_SVH
`define SCRIPT_LEXER_TOKENIZER_MACROS_SVH

// A condition that must hold at every clock edge.
`define SLT_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// A condition that implies a consequence in the same cycle.
`define SLT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition that implies a consequence in the next cycle.
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/slt_pkg.sv */
`default_nettype none
package slt_pkg;

  // Width of the position counter; offsets and lengths wrap at this width.
  localparam int OffsetBits = 16;
  // Number of leading word characters kept for keyword matching.
  localparam int KwMaxChars = 6;
  localparam int PrefixBits = 8 * KwMaxChars;
  localparam int KwCount    = 16;

  // One accepted transaction yields at most four candidate tokens:
  // the token it closes, a token it starts and ends, the token flushed
  // at end of source, and the end token.
  localparam int Slots    = 4;
  localparam int SlotBits = $clog2(Slots);

  localparam int QueueDepth = 2;
  localparam int PtrBits    = $clog2(QueueDepth);
  localparam int CountBits  = $clog2(QueueDepth + 1);

  typedef enum logic [5:0] {
    KindLParen = 6'd0, KindRParen, KindLBrace, KindRBrace, KindComma, KindDot,
    KindMinus, KindPlus, KindSemi, KindSlash, KindStar, KindBang, KindBangEq,
    KindEq, KindEqEq, KindGt, KindGe, KindLt, KindLe, KindIdent, KindString,
    KindNumber, KindIf, KindElse, KindFor, KindAnd, KindFn, KindFalse,
    KindClass, KindNil, KindOr, KindPrint, KindReturn, KindSuper, KindThis,
    KindTrue, KindLet, KindWhile, KindEnd, KindError
  } kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       end_of_source;
  } slt_in_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] start_offset;
    logic [15:0] text_length;
    logic [15:0] line_number;
    logic        last_of_run;
  } slt_out_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] start_offset;
    logic [15:0] text_length;
    logic [15:0] line_number;
  } tok_t;

  // Tokens produced by one transaction, in emission order.
  typedef struct packed {
    tok_t [Slots-1:0] tok;
    logic [Slots-1:0] vld;
  } bundle_t;

  typedef struct packed {
    logic [63:0] text;
    kind_e       kind;
  } kw_t;

  // Keyword text is packed with the first character in the most significant
  // used byte, matching how the word prefix is shifted in.
  function automatic kw_t kw_entry(logic [3:0] idx);
    kw_t e;
    case (idx)
      4'd0:    e = '{text: 64'("if"),     kind: KindIf};
      4'd1:    e = '{text: 64'("else"),   kind: KindElse};
      4'd2:    e = '{text: 64'("for"),    kind: KindFor};
      4'd3:    e = '{text: 64'("and"),    kind: KindAnd};
      4'd4:    e = '{text: 64'("fn"),     kind: KindFn};
      4'd5:    e = '{text: 64'("false"),  kind: KindFalse};
      4'd6:    e = '{text: 64'("class"),  kind: KindClass};
      4'd7:    e = '{text: 64'("nil"),    kind: KindNil};
      4'd8:    e = '{text: 64'("or"),     kind: KindOr};
      4'd9:    e = '{text: 64'("print"),  kind: KindPrint};
      4'd10:   e = '{text: 64'("return"), kind: KindReturn};
      4'd11:   e = '{text: 64'("super"),  kind: KindSuper};
      4'd12:   e = '{text: 64'("this"),   kind: KindThis};
      4'd13:   e = '{text: 64'("true"),   kind: KindTrue};
      4'd14:   e = '{text: 64'("let"),    kind: KindLet};
      default: e = '{text: 64'("while"),  kind: KindWhile};
    endcase
    return e;
  endfunction

  function automatic kind_e kw_lookup(logic [PrefixBits-1:0] prefix, logic too_long);
    kind_e k;
    kw_t   e;
    k = KindIdent;
    if (!too_long) begin
      for (int i = 0; i < KwCount; i++) begin
        e = kw_entry(4'(i));
        if (prefix == e.text[PrefixBits-1:0]) begin
          k = e.kind;
        end
      end
    end
    return k;
  endfunction

  // Offsets leave the block as 16 bits whatever the counter width.
  function automatic logic [15:0] ofs16(logic [OffsetBits-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

endpackage
`default_nettype wire

/* sv/slt_front.sv */
`default_nettype none
`include "script_lexer_tokenizer_macros.svh"
module slt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  slt_pkg::slt_in_t  in_data_i,
  output logic              in_ready_o,
  input  logic              full_i,
  output logic              push_o,
  output slt_pkg::bundle_t  bundle_o
);

  typedef enum logic [3:0] {
    ModeIdle, ModeSlash, ModeBang, ModeEq, ModeGt, ModeLt,
    ModeComment, ModeString, ModeNumber, ModeWord, ModeDead
  } mode_e;

  typedef logic [slt_pkg::OffsetBits-1:0] ofs_t;
  typedef logic [slt_pkg::PrefixBits-1:0] prefix_t;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChReturn  = 8'h0D;
  localparam logic [7:0] ChSpace   = " ";
  localparam logic [7:0] ChQuote   = "\"";
  localparam logic [7:0] ChEqual   = "=";
  localparam logic [7:0] ChSlash   = "/";
  localparam logic [7:0] ChDot     = ".";
  localparam logic [15:0] LineMax  = 16'hFFFF;
  localparam logic [15:0] LineOne  = 16'd1;

  mode_e       mode_q, mode_d;
  ofs_t        tstart_q, tstart_d;
  ofs_t        pos_q, pos_d, pos1, word_len;
  logic [15:0] line_q, line_d, line1;
  prefix_t     prefix_q, prefix_d;
  logic        long_q, long_d;
  logic        run_idle, accept;
  logic [7:0]  c;
  logic        is_digit, is_alpha;
  slt_pkg::bundle_t bundle;

  function automatic logic [15:0] line_inc(logic [15:0] l);
    return (l == LineMax) ? l : l + 16'd1;
  endfunction

  function automatic slt_pkg::tok_t make_tok(slt_pkg::kind_e k, ofs_t off, ofs_t len,
                                             logic [15:0] line);
    slt_pkg::tok_t t;
    t.kind         = k;
    t.start_offset = slt_pkg::ofs16(off);
    t.text_length  = slt_pkg::ofs16(len);
    t.line_number  = line;
    return t;
  endfunction

  function automatic logic is_open(mode_e m);
    logic r;
    case (m) inside
      ModeSlash, ModeBang, ModeEq, ModeGt, ModeLt,
      ModeString, ModeNumber, ModeWord: r = 1'b1;
      default:                          r = 1'b0;
    endcase
    return r;
  endfunction

  // Token for whatever is open in mode m, ended at position pos.
  function automatic slt_pkg::tok_t close_tok(mode_e m, ofs_t ts, ofs_t pos, prefix_t prefix,
                                              logic too_long, logic [15:0] line);
    slt_pkg::tok_t t;
    ofs_t          one;
    one = ofs_t'(1);
    case (m)
      ModeSlash:  t = make_tok(slt_pkg::KindSlash, ts, one, line);
      ModeBang:   t = make_tok(slt_pkg::KindBang, ts, one, line);
      ModeEq:     t = make_tok(slt_pkg::KindEq, ts, one, line);
      ModeGt:     t = make_tok(slt_pkg::KindGt, ts, one, line);
      ModeLt:     t = make_tok(slt_pkg::KindLt, ts, one, line);
      ModeString: t = make_tok(slt_pkg::KindString, ts + one, pos - ts - one, line);
      ModeNumber: t = make_tok(slt_pkg::KindNumber, ts, pos - ts, line);
      ModeWord:   t = make_tok(slt_pkg::kw_lookup(prefix, too_long), ts, pos - ts, line);
      default:    t = make_tok(slt_pkg::KindEnd, ts, '0, line);
    endcase
    return t;
  endfunction

  assign c          = in_data_i.ch;
  assign is_digit   = (c >= "0") && (c <= "9");
  assign is_alpha   = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  assign word_len   = pos_q - tstart_q;
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    mode_d   = mode_q;
    tstart_d = tstart_q;
    pos_d    = pos_q;
    line_d   = line_q;
    prefix_d = prefix_q;
    long_d   = long_q;
    bundle   = '0;
    run_idle = 1'b0;
    pos1     = pos_q;
    line1    = line_q;

    // Slot 0: a token that this byte closes. Slot 1: a token this byte
    // opens and ends at once (punctuation or error).
    if (in_data_i.has_char) begin
      unique case (mode_q)
        ModeDead: begin
        end
        ModeComment: begin
          if (c == ChNewline) begin
            run_idle = 1'b1;
          end
        end
        ModeString: begin
          if (c == ChQuote) begin
            bundle.vld[0] = 1'b1;
            bundle.tok[0] = close_tok(mode_q, tstart_q, pos_q, prefix_q, long_q, line_q);
            mode_d        = ModeIdle;
          end else if (c == ChNewline) begin
            line_d = line_inc(line_q);
          end
        end
        ModeNumber: begin
          if (!(is_digit || c == ChDot)) begin
            bundle.vld[0] = 1'b1;
            bundle.tok[0] = close_tok(mode_q, tstart_q, pos_q, prefix_q, long_q, line_q);
            run_idle      = 1'b1;
          end
        end
        ModeWord: begin
          if (is_alpha || is_digit) begin
            if (word_len < ofs_t'(slt_pkg::KwMaxChars)) begin
              prefix_d = {prefix_q[slt_pkg::PrefixBits-9:0], c};
            end else begin
              long_d = 1'b1;
            end
          end else begin
            bundle.vld[0] = 1'b1;
            bundle.tok[0] = close_tok(mode_q, tstart_q, pos_q, prefix_q, long_q, line_q);
            run_idle      = 1'b1;
          end
        end
        ModeSlash: begin
          if (c == ChSlash) begin
            mode_d = ModeComment;
          end else begin
            bundle.vld[0] = 1'b1;
            bundle.tok[0] = close_tok(mode_q, tstart_q, pos_q, prefix_q, long_q, line_q);
            run_idle      = 1'b1;
          end
        end
        ModeBang, ModeEq, ModeGt, ModeLt: begin
          bundle.vld[0] = 1'b1;
          if (c == ChEqual) begin
            unique case (mode_q)
              ModeBang: bundle.tok[0] = make_tok(slt_pkg::KindBangEq, tstart_q,
                                                 ofs_t'(2), line_q);
              ModeEq:   bundle.tok[0] = make_tok(slt_pkg::KindEqEq, tstart_q,
                                                 ofs_t'(2), line_q);
              ModeGt:   bundle.tok[0] = make_tok(slt_pkg::KindGe, tstart_q,
                                                 ofs_t'(2), line_q);
              default:  bundle.tok[0] = make_tok(slt_pkg::KindLe, tstart_q,
                                                 ofs_t'(2), line_q);
            endcase
            mode_d = ModeIdle;
          end else begin
            bundle.tok[0] = close_tok(mode_q, tstart_q, pos_q, prefix_q, long_q, line_q);
            run_idle      = 1'b1;
          end
        end
        default: run_idle = 1'b1;
      endcase

      if (run_idle) begin
        mode_d   = ModeIdle;
        tstart_d = pos_q;
        bundle.tok[1] = make_tok(slt_pkg::KindLParen, pos_q, ofs_t'(1), line_q);
        case (c)
          "(":  bundle.vld[1] = 1'b1;
          ")": begin
            bundle.vld[1] = 1'b1; bundle.tok[1].kind = slt_pkg::KindRParen;
          end
          "{": begin
            bundle.vld[1] = 1'b1; bundle.tok[1].kind = slt_pkg::KindLBrace;
          end
          "}": begin
            bundle.vld[1] = 1'b1; bundle.tok[1].kind = slt_pkg::KindRBrace;
          end
          ",": begin
            bundle.vld[1] = 1'b1; bundle.tok[1].kind = slt_pkg::KindComma;
          end
          ".": begin
            bundle.vld[1] = 1'b1; bundle.tok[1].kind = slt_pkg::KindDot;
          end
          "-": begin
            bundle.vld[1] = 1'b1; bundle.tok[1].kind = slt_pkg::KindMinus;
          end
          "+": begin
            bundle.vld[1] = 1'b1; bundle.tok[1].kind = slt_pkg::KindPlus;
          end
          ";": begin
            bundle.vld[1] = 1'b1; bundle.tok[1].kind = slt_pkg::KindSemi;
          end
          "*": begin
            bundle.vld[1] = 1'b1; bundle.tok[1].kind = slt_pkg::KindStar;
          end
          "!":       mode_d = ModeBang;
          ChEqual:   mode_d = ModeEq;
          ">":       mode_d = ModeGt;
          "<":       mode_d = ModeLt;
          ChSlash:   mode_d = ModeSlash;
          ChQuote:   mode_d = ModeString;
          ChNewline: line_d = line_inc(line_q);
          ChTab, ChReturn, ChSpace: begin
          end
          default: begin
            if (is_digit) begin
              mode_d = ModeNumber;
            end else if (is_alpha) begin
              mode_d   = ModeWord;
              prefix_d = prefix_t'(c);
              long_d   = 1'b0;
            end else begin
              bundle.vld[1]      = 1'b1;
              bundle.tok[1].kind = slt_pkg::KindError;
              mode_d             = ModeDead;
            end
          end
        endcase
      end
      pos1 = pos_q + ofs_t'(1);
    end

    pos_d = pos1;
    line1 = line_d;

    // Slots 2 and 3: flush of the open token and the end token.
    if (in_data_i.end_of_source) begin
      if (mode_d != ModeDead) begin
        bundle.vld[2] = is_open(mode_d);
        bundle.tok[2] = close_tok(mode_d, tstart_d, pos1, prefix_d, long_d, line1);
        bundle.vld[3] = 1'b1;
        bundle.tok[3] = make_tok(slt_pkg::KindEnd, pos1, '0, line1);
      end
      mode_d   = ModeIdle;
      tstart_d = '0;
      pos_d    = '0;
      line_d   = LineOne;
      prefix_d = '0;
      long_d   = 1'b0;
    end
  end

  assign push_o   = accept && (bundle.vld != '0);
  assign bundle_o = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      tstart_q <= '0;
      pos_q    <= '0;
      line_q   <= LineOne;
      prefix_q <= '0;
      long_q   <= 1'b0;
    end else if (accept) begin
      mode_q   <= mode_d;
      tstart_q <= tstart_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
      prefix_q <= prefix_d;
      long_q   <= long_d;
    end
  end

  `SLT_ASSERT_IMPL(a_dead_is_silent,
                   accept && (mode_q == ModeDead) && !in_data_i.end_of_source, !push_o,
                   "scanner emitted a token after an error")
  `SLT_ASSERT_NEXT(a_end_clears_state, accept && in_data_i.end_of_source,
                   (mode_q == ModeIdle) && (pos_q == '0) && (line_q == LineOne),
                   "end of source did not restore the scanner state")
  `SLT_ASSERT_IMPL(a_at_most_three, push_o, $countones(bundle_o.vld) <= 3,
                   "one transaction produced more than three tokens")

endmodule
`default_nettype wire

/* sv/slt_fifo.sv */
`default_nettype none
`include "script_lexer_tokenizer_macros.svh"
module slt_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  slt_pkg::bundle_t  data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output slt_pkg::bundle_t  head_o
);

  slt_pkg::bundle_t [slt_pkg::QueueDepth-1:0] mem_q;
  logic [slt_pkg::PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [slt_pkg::CountBits-1:0] count_q;

  function automatic logic [slt_pkg::PtrBits-1:0] ptr_next(logic [slt_pkg::PtrBits-1:0] p);
    return (p == slt_pkg::PtrBits'(slt_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_q == slt_pkg::CountBits'(slt_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `SLT_ASSERT_IMPL(a_no_overflow, push_i, !full_o, "write into a full token queue")
  `SLT_ASSERT_IMPL(a_no_underflow, pop_i, !empty_o, "read from an empty token queue")

endmodule
`default_nettype wire

/* sv/slt_back.sv */
`default_nettype none
`include "script_lexer_tokenizer_macros.svh"
module slt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  slt_pkg::bundle_t  head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output slt_pkg::slt_out_t out_data_o
);

  logic [slt_pkg::Slots-1:0]    done_q, done_d, pending, sel_oh;
  logic [slt_pkg::SlotBits-1:0] sel_idx;
  logic                         sel_last, load, take, found;
  logic                         out_valid_q;
  slt_pkg::slt_out_t            out_q;
  slt_pkg::tok_t                sel_tok;

  // Tokens of the head entry that have not gone out yet; the oldest is the lowest slot.
  assign pending = head_i.vld & ~done_q;

  always_comb begin
    sel_oh  = '0;
    sel_idx = '0;
    found   = 1'b0;
    for (int i = 0; i < slt_pkg::Slots; i++) begin
      if (pending[i] && !found) begin
        found     = 1'b1;
        sel_oh[i] = 1'b1;
        sel_idx   = slt_pkg::SlotBits'(i);
      end
    end
  end

  assign sel_tok  = head_i.tok[sel_idx];
  assign sel_last = ((pending & ~sel_oh) == '0);
  assign load     = !out_valid_q || out_ready_i;
  assign take     = load && !empty_i;
  assign pop_o    = take && sel_last;

  always_comb begin
    done_d = done_q;
    if (take) begin
      done_d = sel_last ? '0 : (done_q | sel_oh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= '0;
    end else begin
      done_q <= done_d;
      if (load) begin
        out_valid_q <= !empty_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q.kind         <= sel_tok.kind;
      out_q.start_offset <= sel_tok.start_offset;
      out_q.text_length  <= sel_tok.text_length;
      out_q.line_number  <= sel_tok.line_number;
      out_q.last_of_run  <= sel_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SLT_ASSERT_IMPL(a_last_clears_progress, out_valid_q && out_q.last_of_run, done_q == '0,
                   "final token of a transaction left slots marked as sent")

endmodule
`default_nettype wire

/* sv/script_lexer_tokenizer.sv */
// Channel   Direction  Signals                              Payload
// in        input      in_valid_i / in_ready_o / in_data_i  slt_pkg::slt_in_t
// out       output     out_valid_o / out_ready_i / out_data_o slt_pkg::slt_out_t
//
// Flow: the front accepts one transaction per clock while the token queue has room,
// and the output register delivers one token per clock unless out_ready_i holds it;
// the first token of a transaction goes through the queue, then the output register.
// Reset: the scanner returns to idle on line one at offset zero and the queue empties.
// Stalls: a low out_ready_i holds the output register, then fills the two-entry queue,
// and only then drops in_ready_o.
`default_nettype none
module script_lexer_tokenizer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  slt_pkg::slt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output slt_pkg::slt_out_t out_data_o
);

  // The front scans each byte in the cycle it is accepted and hands every token
  // that byte causes to the queue as one entry. The back walks the slots of the
  // head entry in order and marks the final one of each transaction.
  logic             push, pop, full, empty;
  slt_pkg::bundle_t push_data, head;

  slt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .full_i     (full),
    .push_o     (push),
    .bundle_o   (push_data)
  );

  // The queue decouples scanning from delivery so that a stalled sink does not
  // immediately stop the source.
  slt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  slt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
